// File: sv/dtpq_pkg.sv
// ----------------------------------------------------------------------------
// dtpq_pkg
// Shared types and constants for the deferred task priority queue.
// ----------------------------------------------------------------------------
package dtpq_pkg;

	localparam int PoolDepth  = 16;
	localparam int MaxResults = 16;
	localparam int PriW       = 16;
	localparam int HndW       = 8;
	localparam int ThrW       = 17;
	localparam int KW         = $clog2(MaxResults + 1);

	localparam logic CMD_ENQUEUE  = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [PriW-1:0] task_priority;
		logic [HndW-1:0] handler_index;
		logic [ThrW-1:0] run_threshold;
	} in_item_t;

	typedef struct packed {
		logic            task_valid;
		logic [HndW-1:0] out_handler;
		logic [PriW-1:0] out_priority;
		logic            status;
		logic            last;
	} out_item_t;

	typedef struct packed {
		logic            occ;
		logic [PriW-1:0] pri;
		logic [HndW-1:0] hnd;
	} entry_t;

	// row control, broadcast to every cell
	typedef struct packed {
		logic            ins;
		logic            pop;
		logic [PriW-1:0] pri;
		logic [HndW-1:0] hnd;
	} ctl_t;

	localparam entry_t EMPTY_ENTRY = '0;

endpackage

// File: sv/deferred_task_priority_queue_top.sv
// ----------------------------------------------------------------------------
// deferred_task_priority_queue_top
// Sorted pool of deferred tasks with threshold-gated dispatch.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake               Payload
//  req      in   req_valid / req_ready   dtpq_pkg::in_item_t
//  rsp      out  rsp_valid / rsp_ready   dtpq_pkg::out_item_t
//
// Enqueue: the task drops into place in the cell row in the accepting
// cycle and its status transaction is loaded at the same edge.
// Dispatch: the threshold is captured at the accepting edge, then one popped
// task per cycle the output register can take.
// The row shift (one pop per cycle) sets the drain rate.
// Reset clears all occupied flags and the sequencer; no clearing pass.
// A stalled rsp holds the sequencer; req is refused until it is idle.
//
module deferred_task_priority_queue_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dtpq_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dtpq_pkg::out_item_t rsp
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                        state_q;
	logic [dtpq_pkg::ThrW-1:0]   thr_q;
	logic [dtpq_pkg::KW-1:0]     k_q;
	logic                        rsp_valid_q;
	dtpq_pkg::out_item_t         rsp_q;

	dtpq_pkg::ctl_t   ctl;
	dtpq_pkg::entry_t head;
	dtpq_pkg::entry_t second;
	logic             full;

	logic o_free;
	logic req_acc;
	logic head_elig;
	logic next_elig;
	logic drain_step;
	logic take_pop;
	logic drain_last;

	// output register free this cycle, either empty or being drained
	assign o_free    = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && o_free;
	assign req_acc   = req_valid && req_ready;

	// 17-bit compare: an idle threshold clears every 16-bit priority
	assign head_elig = head.occ && ({1'b0, head.pri} < thr_q);
	assign next_elig = second.occ && ({1'b0, second.pri} < thr_q);

	assign drain_step = (state_q == ST_DRAIN) && o_free;
	assign take_pop   = drain_step && head_elig;
	assign drain_last = !next_elig ||
		(k_q == dtpq_pkg::KW'(dtpq_pkg::MaxResults - 1));

	always_comb begin
		ctl.ins = req_acc && (req.cmd == dtpq_pkg::CMD_ENQUEUE) && !full;
		ctl.pop = take_pop;
		ctl.pri = req.task_priority;
		ctl.hnd = req.handler_index;
	end

	dtpq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (head),
		.second (second),
		.full   (full)
	);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						k_q <= '0;
						if (req.cmd == dtpq_pkg::CMD_DISPATCH) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_step) begin
						k_q <= k_q + 1'b1;
						// an empty result only happens on the first step
						if (!head_elig || drain_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if ((req_acc && req.cmd == dtpq_pkg::CMD_ENQUEUE) || drain_step) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// threshold and result payload
	always_ff @(posedge clk) begin
		if (req_acc && req.cmd == dtpq_pkg::CMD_DISPATCH) begin
			thr_q <= req.run_threshold;
		end
		if (req_acc && req.cmd == dtpq_pkg::CMD_ENQUEUE) begin
			rsp_q <= '{task_valid: 1'b0, out_handler: '0, out_priority: '0,
				status: full ? dtpq_pkg::STATUS_DROPPED : dtpq_pkg::STATUS_OK,
				last: 1'b1};
		end else if (drain_step) begin
			if (head_elig) begin
				rsp_q <= '{task_valid: 1'b1, out_handler: head.hnd,
					out_priority: head.pri, status: dtpq_pkg::STATUS_OK,
					last: drain_last};
			end else begin
				rsp_q <= '{task_valid: 1'b0, out_handler: '0, out_priority: '0,
					status: dtpq_pkg::STATUS_OK, last: 1'b1};
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/dtpq_cell.sv
// ----------------------------------------------------------------------------
// dtpq_cell
// One slot of the sorted row: keeps, takes the new task, or shifts.
// ----------------------------------------------------------------------------
module dtpq_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  dtpq_pkg::ctl_t   ctl,
	input  logic             prev_keep,
	input  dtpq_pkg::entry_t prev,
	input  dtpq_pkg::entry_t next,
	output logic             keep,
	output dtpq_pkg::entry_t cur
);

	logic                      occ_q;
	logic [dtpq_pkg::PriW-1:0] pri_q;
	logic [dtpq_pkg::HndW-1:0] hnd_q;

	assign cur  = '{occ: occ_q, pri: pri_q, hnd: hnd_q};
	// equal priorities stay ahead of the newcomer
	assign keep = occ_q && (pri_q <= ctl.pri);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.ins && !keep) begin
			occ_q <= prev_keep ? 1'b1 : prev.occ;
		end else if (ctl.pop) begin
			occ_q <= next.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			pri_q <= prev_keep ? ctl.pri : prev.pri;
			hnd_q <= prev_keep ? ctl.hnd : prev.hnd;
		end else if (ctl.pop) begin
			pri_q <= next.pri;
			hnd_q <= next.hnd;
		end
	end

endmodule

// File: sv/dtpq_chain.sv
// ----------------------------------------------------------------------------
// dtpq_chain
// Row of PoolDepth cells; head at cell 0, occupied cells form a prefix.
// ----------------------------------------------------------------------------
module dtpq_chain (
	input  logic             clk,
	input  logic             arst_n,
	input  dtpq_pkg::ctl_t   ctl,
	output dtpq_pkg::entry_t head,
	output dtpq_pkg::entry_t second,
	output logic             full
);

	dtpq_pkg::entry_t ent    [dtpq_pkg::PoolDepth];
	dtpq_pkg::entry_t prev_e [dtpq_pkg::PoolDepth];
	dtpq_pkg::entry_t next_e [dtpq_pkg::PoolDepth];
	logic             keep   [dtpq_pkg::PoolDepth];
	logic             prev_k [dtpq_pkg::PoolDepth];

	for (genvar i = 0; i < dtpq_pkg::PoolDepth; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_e[i] = dtpq_pkg::EMPTY_ENTRY;
			assign prev_k[i] = 1'b1;
		end else begin : g_mid
			assign prev_e[i] = ent[i-1];
			assign prev_k[i] = keep[i-1];
		end
		if (i == dtpq_pkg::PoolDepth - 1) begin : g_end
			assign next_e[i] = dtpq_pkg::EMPTY_ENTRY;
		end else begin : g_nxt
			assign next_e[i] = ent[i+1];
		end

		dtpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_keep (prev_k[i]),
			.prev      (prev_e[i]),
			.next      (next_e[i]),
			.keep      (keep[i]),
			.cur       (ent[i])
		);
	end

	assign head   = ent[0];
	assign second = ent[1];
	assign full   = ent[dtpq_pkg::PoolDepth-1].occ;

endmodule

// File: sv/dtpq_checker.sv
// ----------------------------------------------------------------------------
// dtpq_checker
// Port-level checks for the deferred task priority queue.
// ----------------------------------------------------------------------------
module dtpq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input dtpq_pkg::in_item_t  req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input dtpq_pkg::out_item_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp transaction changed while stalled");

	a_enq_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.cmd == dtpq_pkg::CMD_ENQUEUE)
		|=> rsp_valid && rsp.last && !rsp.task_valid)
		else $error("enqueue not answered by a single status transaction");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.task_valid
		|-> rsp.last && (rsp.out_handler == '0) && (rsp.out_priority == '0))
		else $error("taskless transaction not final or not zeroed");

	a_drop_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == dtpq_pkg::STATUS_DROPPED) |-> !rsp.task_valid)
		else $error("drop flagged on a popped task");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !(rsp_valid && !rsp_ready))
		else $error("req taken while a result is stalled");

endmodule

bind deferred_task_priority_queue_top dtpq_checker u_dtpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: bench/deferred_task_priority_queue_top_test.sv
// ----------------------------------------------------------------------------
// deferred_task_priority_queue_top_test
// Self-checking bench for the deferred task priority queue.
// A queue of request transactions is built up front: a short directed run
// over ties, thresholds and the idle threshold, then fill/drain sequences with
// random content mixed with noise. A clocked driver offers them with random
// gaps and a clocked monitor takes responses with random stalls. Two long
// receiver hold-offs back the block up. Every accepted request is run through
// a local sorted-pool model. Each response is checked field by field against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module deferred_task_priority_queue_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// clock, reset and DUT ports; every input starts at a known value
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	dtpq_pkg::in_item_t  req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	dtpq_pkg::out_item_t rsp;

	// stimulus backlog and its bookkeeping
	dtpq_pkg::in_item_t  req_backlog[$];
	int                  items_total = 0;
	int                  items_taken = 0;

	// predicted responses, oldest first
	dtpq_pkg::out_item_t rsp_due[$];
	int                  errors = 0;
	int                  rsp_taken = 0;

	// local copy of the sorted pool: slot 0 is the most urgent task
	logic [dtpq_pkg::PriW-1:0] pool_pri[dtpq_pkg::PoolDepth];
	logic [dtpq_pkg::HndW-1:0] pool_hnd[dtpq_pkg::PoolDepth];
	int                        pool_fill = 0;

	// idle control
	int send_gap;
	int recv_gap;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int hold_left;
	int holds_done;

	deferred_task_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Pool model. Works out every response one request transaction causes and
	// queues them in order.
	// ------------------------------------------------------------------------
	task automatic model_request(input dtpq_pkg::in_item_t it);
		dtpq_pkg::out_item_t       r;
		int                        pos;
		int                        k;
		logic [dtpq_pkg::ThrW-1:0] thr;
		begin
			r = '0;
			if (it.cmd == dtpq_pkg::CMD_ENQUEUE) begin
				r.last = 1'b1;
				if (pool_fill >= dtpq_pkg::PoolDepth) begin
					// full pool: task discarded, pool left as it was
					r.status = dtpq_pkg::STATUS_DROPPED;
				end else begin
					// goes behind every task of equal priority
					pos = 0;
					while (pos < pool_fill && pool_pri[pos] <= it.task_priority)
						pos++;
					for (int i = pool_fill; i > pos; i--) begin
						pool_pri[i] = pool_pri[i-1];
						pool_hnd[i] = pool_hnd[i-1];
					end
					pool_pri[pos] = it.task_priority;
					pool_hnd[pos] = it.handler_index;
					pool_fill++;
					r.status = dtpq_pkg::STATUS_OK;
				end
				rsp_due.push_back(r);
			end else begin
				// anything from the idle value upwards makes every task eligible
				thr = it.run_threshold;
				if (thr > 17'h10000)
					thr = 17'h10000;
				k = 0;
				while (k < dtpq_pkg::MaxResults && pool_fill > 0 &&
						{1'b0, pool_pri[0]} < thr) begin
					r = '0;
					r.task_valid   = 1'b1;
					r.out_handler  = pool_hnd[0];
					r.out_priority = pool_pri[0];
					r.status       = dtpq_pkg::STATUS_OK;
					for (int i = 0; i + 1 < pool_fill; i++) begin
						pool_pri[i] = pool_pri[i+1];
						pool_hnd[i] = pool_hnd[i+1];
					end
					pool_fill--;
					k++;
					// last once the drain limit is hit or the new head is not eligible
					r.last = !(k < dtpq_pkg::MaxResults && pool_fill > 0 &&
						{1'b0, pool_pri[0]} < thr);
					rsp_due.push_back(r);
				end
				if (k == 0) begin
					// nothing eligible: a single empty transaction
					r = '0;
					r.status = dtpq_pkg::STATUS_OK;
					r.last   = 1'b1;
					rsp_due.push_back(r);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		begin
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		end
	endtask

	task automatic compare_rsp(input dtpq_pkg::out_item_t got);
		dtpq_pkg::out_item_t want;
		begin
			if (rsp_due.size() == 0) begin
				$error("response transaction with nothing outstanding: 0x%0h", got);
				errors++;
			end else begin
				want = rsp_due.pop_front();
				check_field("task_valid", 32'(want.task_valid), 32'(got.task_valid));
				check_field("out_handler", 32'(want.out_handler), 32'(got.out_handler));
				check_field("out_priority", 32'(want.out_priority),
					32'(got.out_priority));
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers. Fields that the command ignores are still randomised
	// so every bit of the request toggles.
	// ------------------------------------------------------------------------
	function automatic dtpq_pkg::in_item_t rand_item();
		dtpq_pkg::in_item_t r;
		begin
			r.cmd           = 1'($urandom_range(0, 1));
			r.task_priority = dtpq_pkg::PriW'($urandom_range(0, 65535));
			r.handler_index = dtpq_pkg::HndW'($urandom_range(0, 255));
			r.run_threshold = dtpq_pkg::ThrW'($urandom_range(0, 131071));
			return r;
		end
	endfunction

	task automatic add_enqueue(input logic [dtpq_pkg::PriW-1:0] pri,
			input logic [dtpq_pkg::HndW-1:0] hnd);
		dtpq_pkg::in_item_t r;
		begin
			r = rand_item();
			r.cmd           = dtpq_pkg::CMD_ENQUEUE;
			r.task_priority = pri;
			r.handler_index = hnd;
			req_backlog.push_back(r);
		end
	endtask

	task automatic add_dispatch(input logic [dtpq_pkg::ThrW-1:0] thr);
		dtpq_pkg::in_item_t r;
		begin
			r = rand_item();
			r.cmd           = dtpq_pkg::CMD_DISPATCH;
			r.run_threshold = thr;
			req_backlog.push_back(r);
		end
	endtask

	function automatic logic [dtpq_pkg::HndW-1:0] pick_handler();
		return dtpq_pkg::HndW'($urandom_range(0, 255));
	endfunction

	// narrow ranges at both ends collide often, which gives plenty of ties
	function automatic logic [dtpq_pkg::PriW-1:0] pick_priority();
		case ($urandom_range(0, 3))
			0: return dtpq_pkg::PriW'($urandom_range(0, 15));
			1: return dtpq_pkg::PriW'($urandom_range(65520, 65535));
			default: return dtpq_pkg::PriW'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [dtpq_pkg::ThrW-1:0] pick_threshold();
		case ($urandom_range(0, 4))
			0: return dtpq_pkg::ThrW'($urandom_range(0, 16));
			1: return dtpq_pkg::ThrW'($urandom_range(0, 65535));
			2: return dtpq_pkg::ThrW'($urandom_range(65536, 131071));
			3: return dtpq_pkg::ThrW'($urandom_range(65530, 65537));
			default: return dtpq_pkg::ThrW'($urandom_range(0, 131071));
		endcase
	endfunction

	// mostly no gap or a short one, now and then a long one
	function automatic int gap_pick(input bit calm);
		int r;
		begin
			if (calm)
				return 0;
			r = $urandom_range(0, 19);
			if (r < 10)
				return 0;
			if (r < 18)
				return $urandom_range(1, 3);
			return $urandom_range(8, 30);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offers the backlog one transaction at a time. Valid stays up with
	// the payload frozen until the block takes it; the model runs on the
	// accepting edge.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap  <= 0;
		end else begin
			if (req_valid && req_ready) begin
				model_request(req);
				items_taken <= items_taken + 1;
			end
			if (!req_valid || req_ready) begin
				if (send_gap != 0) begin
					req_valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (req_backlog.size() != 0) begin
					req_valid <= 1'b1;
					req       <= req_backlog.pop_front();
					if ($urandom_range(0, 39) == 0)
						send_calm = !send_calm;
					send_gap <= gap_pick(send_calm);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each accepted response, then decides whether to stall.
	// A hold-off from the pressure process overrides the random stalls.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				compare_rsp(rsp);
				rsp_taken <= rsp_taken + 1;
			end
			if (hold_left != 0) begin
				rsp_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				rsp_ready <= 1'b0;
				recv_gap  <= recv_gap - 1;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_gap <= gap_pick(recv_calm);
			end
		end
	end

	// Pressure: long receiver hold-offs while the driver keeps offering, so
	// the sequencer backs up and the request side is refused.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && rsp_taken >= 30 + holds_done * 200) begin
			hold_left  <= 150;
			holds_done <= holds_done + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus build, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		int kind;
		int n;
		logic [dtpq_pkg::PriW-1:0] p;

		// directed: empty pool, extremes, ties and threshold edges
		add_dispatch(17'h1FFFF);          // nothing queued: empty transaction
		add_enqueue(16'hFFFF, 8'hFF);
		add_enqueue(16'h0000, 8'h00);
		add_enqueue(16'd5, 8'd1);
		add_enqueue(16'd5, 8'd2);         // ties keep arrival order
		add_enqueue(16'd5, 8'd3);
		add_dispatch(17'd0);              // strict compare: priority 0 stays
		add_dispatch(17'd5);              // pops priority 0 only
		add_dispatch(17'd6);              // the three tied tasks, in order
		add_dispatch(17'h0FFFF);          // 0xFFFF is not below 0xFFFF
		add_dispatch(17'h10000);          // idle: takes the 0xFFFF task
		add_enqueue(16'h8000, 8'h80);
		add_enqueue(16'h7FFF, 8'h7F);
		add_dispatch(17'h1FFFF);          // above idle behaves as idle
		add_dispatch(17'h10000);          // empty again

		// fill past capacity to force drops, then a drain of the whole pool
		for (int i = 0; i < dtpq_pkg::PoolDepth + 2; i++)
			add_enqueue(pick_priority(), pick_handler());
		add_dispatch(17'h10000);

		// random sequences: mostly fill-then-dispatch with random content
		while (req_backlog.size() < 210) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					add_enqueue(pick_priority(), pick_handler());
				add_dispatch(pick_threshold());
			end else if (kind < 7) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					add_dispatch(pick_threshold());
			end else if (kind == 7) begin
				// run of equal priorities
				p = pick_priority();
				n = $urandom_range(2, 8);
				for (int i = 0; i < n; i++)
					add_enqueue(p, pick_handler());
				add_dispatch({1'b0, p} + dtpq_pkg::ThrW'($urandom_range(0, 1)));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					req_backlog.push_back(rand_item());
			end
		end
		items_total = req_backlog.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// all requests in, all responses back, then a quiet tail to catch
		// anything extra the block might still send
		while (items_taken != items_total)
			@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0 && rsp_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
sv/dtpq_pkg.sv
sv/dtpq_cell.sv
sv/dtpq_chain.sv
sv/deferred_task_priority_queue_top.sv
sv/dtpq_checker.sv
bench/deferred_task_priority_queue_top_test.sv
